/* hdl/gpb_pkg.sv */
// Shared constants, types and controller/datapath interface for the gait parameter blender.
package gpb_pkg;

    localparam int LEG_COUNT  = 4;

    localparam int TIME_W     = 32;
    localparam int DUR_W      = 24;
    localparam int FIELD_W    = 24;
    localparam int PHASE_W    = 16;
    localparam int FRAC_W     = 17;
    localparam int FRAC_SHIFT = 16;

    // stance, swing, one phase per leg, step height
    localparam int NUM_FIELDS = LEG_COUNT + 3;
    localparam int F_STANCE   = 0;
    localparam int F_SWING    = 1;
    localparam int F_PHASE0   = 2;
    localparam int F_HEIGHT   = F_PHASE0 + LEG_COUNT;

    localparam int IN_W  = TIME_W + 2 * DUR_W + (LEG_COUNT + 1) * PHASE_W;
    localparam int OUT_W = 2 * FIELD_W + (LEG_COUNT + 1) * PHASE_W;

    // bit positions inside the packed item words
    localparam int IN_STANCE_LSB  = TIME_W;
    localparam int IN_SWING_LSB   = TIME_W + DUR_W;
    localparam int IN_PHASE_LSB   = TIME_W + 2 * DUR_W;
    localparam int OUT_PHASE_LSB  = 2 * FIELD_W;

    localparam int DIV_STEPS = FRAC_SHIFT;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int IDX_W     = $clog2(NUM_FIELDS);

    // signed difference times zero-extended fraction
    localparam int DIFF_W = FIELD_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_W + 1;

    localparam logic [FRAC_W-1:0]        FRAC_ONE       = FRAC_W'(1) << FRAC_SHIFT;
    localparam logic [DUR_W-1:0]         DURATION_RESET = DUR_W'(500000);
    localparam logic signed [PROD_W-1:0] ROUND_HALF     = PROD_W'(1) << (FRAC_SHIFT - 1);

    typedef logic [FIELD_W-1:0] field_t;

    typedef struct packed {
        logic             load;
        logic             cfg_wr;
        logic             prep;
        logic             div_step;
        logic             mul;
        logic             acc;
        logic [IDX_W-1:0] idx;
        logic             out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic skip_div;
    } dp_status_t;

endpackage

/* hdl/gait_parameter_blender_core.sv */
// Gait parameter blender: linear ramp of gait targets over a configurable duration.
//
// Usage:
//   s_axis carries one item per gait update: time and target gait parameters.
//   m_axis returns one item per input item with the blended parameters; tuser
//   flags that a blend is still running after this item.
//   cfg carries blend_duration in microseconds; a write ends any running blend.
//   Write it only while the block is idle.
// Sequence:
//   An item goes through a prep step, the bit-serial fraction divider
//   (skipped when no blend runs or the fraction is saturated), a multiply
//   and an accumulate step per field on the shared multiplier and a
//   handoff step; the next item is accepted only after the handoff, once
//   the block is back in idle.
// Reset:
//   Clears blend state, sets blend_duration to 500000 and drops m_axis_tvalid.
// Backpressure:
//   A result waits in the output register; the next item is accepted and
//   computed meanwhile and holds in the handoff step until the register frees.
module gait_parameter_blender_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // now_time, stance_time, swing_time, phase_0..phase_3, step_height
    input  logic [gpb_pkg::IN_W-1:0]  s_axis_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [gpb_pkg::DUR_W-1:0] cfg_data,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // stance_out, swing_out, phase_out_0..phase_out_3, height_out
    output logic [gpb_pkg::OUT_W-1:0] m_axis_tdata,
    // blending
    output logic                      m_axis_tuser
);
    import gpb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    gpb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    gpb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_data      (s_axis_tdata),
        .cfg_data     (cfg_data),
        .out_data     (m_axis_tdata),
        .out_blending (m_axis_tuser)
    );

endmodule

/* hdl/gpb_datapath.sv */
// Datapath: gait state, fraction divider, shared blend multiplier and result registers.
module gpb_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  gpb_pkg::dp_cmd_t           cmd,
    output gpb_pkg::dp_status_t        status,
    input  logic [gpb_pkg::IN_W-1:0]   in_data,
    input  logic [gpb_pkg::DUR_W-1:0]  cfg_data,
    output logic [gpb_pkg::OUT_W-1:0]  out_data,
    output logic                       out_blending
);
    import gpb_pkg::*;

    logic [DUR_W-1:0]      dur_reg;
    logic                  primed_reg;
    logic                  in_blend_reg;
    logic [TIME_W-1:0]     start_reg;
    logic [TIME_W-1:0]     now_reg;
    field_t                tgt_reg  [NUM_FIELDS];
    field_t                old_reg  [NUM_FIELDS];
    field_t                prev_reg [NUM_FIELDS];
    field_t                res_reg  [NUM_FIELDS];
    logic [DUR_W-1:0]      rem_reg;
    logic [FRAC_SHIFT-1:0] quo_reg;
    logic [FRAC_W-1:0]     frac_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [OUT_W-1:0]      out_data_reg;
    logic                  out_blend_reg;

    logic [TIME_W-1:0]     in_now;
    field_t                in_fld [NUM_FIELDS];
    logic                  changed;
    logic [TIME_W-1:0]     elapsed;
    logic                  skip;
    logic [DUR_W:0]        rem_shift;
    logic                  rem_ge;
    logic [DUR_W-1:0]      rem_next;
    logic [FRAC_SHIFT-1:0] quo_next;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] rounded;
    field_t                res_next;
    logic [OUT_W-1:0]      out_pack;

    // unpack the item into uniform-width fields
    always_comb
    begin
        in_now            = in_data[TIME_W-1:0];
        in_fld[F_STANCE]  = in_data[IN_STANCE_LSB +: DUR_W];
        in_fld[F_SWING]   = in_data[IN_SWING_LSB +: DUR_W];
        for (int i = 0; i <= LEG_COUNT; i++)
        begin
            in_fld[F_PHASE0 + i] = {{(FIELD_W - PHASE_W){1'b0}},
                                    in_data[IN_PHASE_LSB + i * PHASE_W +: PHASE_W]};
        end
    end

    always_comb
    begin
        changed = 1'b0;
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            if (in_fld[i] != prev_reg[i])
            begin
                changed = 1'b1;
            end
        end
    end

    assign elapsed = now_reg - start_reg;
    // fraction saturates at one when not blending, duration is zero or time has run out
    assign skip = !in_blend_reg || (dur_reg == '0) ||
                  (elapsed >= {{(TIME_W - DUR_W){1'b0}}, dur_reg});
    assign status.skip_div = skip;

    // one restoring division step: remainder stays below the duration
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, dur_reg};
    assign rem_next  = rem_ge ? DUR_W'(rem_shift - {1'b0, dur_reg}) : rem_shift[DUR_W-1:0];
    assign quo_next  = {quo_reg[FRAC_SHIFT-2:0], rem_ge};

    assign diff      = $signed({1'b0, tgt_reg[cmd.idx]}) - $signed({1'b0, old_reg[cmd.idx]});
    assign prod_next = diff * $signed({1'b0, frac_reg});
    assign rounded   = (prod_reg + ROUND_HALF) >>> FRAC_SHIFT;
    assign res_next  = old_reg[cmd.idx] + rounded[FIELD_W-1:0];

    always_comb
    begin
        out_pack = '0;
        out_pack[0 +: FIELD_W]       = res_reg[F_STANCE];
        out_pack[FIELD_W +: FIELD_W] = res_reg[F_SWING];
        for (int i = 0; i <= LEG_COUNT; i++)
        begin
            out_pack[OUT_PHASE_LSB + i * PHASE_W +: PHASE_W] =
                res_reg[F_PHASE0 + i][PHASE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg      <= DURATION_RESET;
            primed_reg   <= 1'b0;
            in_blend_reg <= 1'b0;
            start_reg    <= '0;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                old_reg[i]  <= '0;
                prev_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.cfg_wr)
            begin
                dur_reg      <= cfg_data;
                in_blend_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                primed_reg <= 1'b1;
                for (int i = 0; i < NUM_FIELDS; i++)
                begin
                    prev_reg[i] <= in_fld[i];
                end
                if (!primed_reg)
                begin
                    in_blend_reg <= 1'b0;
                end
                else if (changed)
                begin
                    // restart the blend from the previous targets
                    in_blend_reg <= 1'b1;
                    start_reg    <= in_now;
                    for (int i = 0; i < NUM_FIELDS; i++)
                    begin
                        old_reg[i] <= prev_reg[i];
                    end
                end
            end
            if (cmd.prep && skip)
            begin
                in_blend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg <= in_now;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                tgt_reg[i] <= in_fld[i];
            end
        end
        if (cmd.prep)
        begin
            rem_reg  <= elapsed[DUR_W-1:0];
            quo_reg  <= '0;
            frac_reg <= FRAC_ONE;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            frac_reg <= {1'b0, quo_next};
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.acc)
        begin
            res_reg[cmd.idx] <= res_next;
        end
        if (cmd.out_load)
        begin
            out_data_reg  <= out_pack;
            out_blend_reg <= in_blend_reg;
        end
    end

    assign out_data     = out_data_reg;
    assign out_blending = out_blend_reg;

endmodule

/* hdl/gpb_ctrl.sv */
// Controller: sequences load, divide, per-field blend and output handoff for each item.
module gpb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output gpb_pkg::dp_cmd_t     cmd,
    input  gpb_pkg::dp_status_t  status
);
    import gpb_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg, m_valid_next;

    assign cfg_ready = (state_reg == ST_IDLE);
    // configuration wins over an item offered in the same cycle
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign m_valid   = m_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.cfg_wr = cfg_valid;
                if (s_valid && !cfg_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                idx_next   = '0;
                state_next = status.skip_div ? ST_MUL : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (idx_reg == IDX_W'(NUM_FIELDS - 1))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* hdl/gpb_checker.sv */
// Port-level checker for the gait parameter blender, bound to the top level.
module gpb_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [gpb_pkg::IN_W-1:0]  s_axis_tdata,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [gpb_pkg::DUR_W-1:0] cfg_data,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [gpb_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                      m_axis_tuser
);

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an item was accepted");

    // a configuration write never coincides with an item accept
    a_cfg_excludes_item: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !(s_axis_tvalid && s_axis_tready))
        else $error("configuration write and item accept in the same cycle");

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    // reset seen at an edge leaves the output idle by the next edge
    a_no_valid_in_reset: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid during reset");

endmodule

bind gait_parameter_blender_core gpb_checker u_gpb_checker (.*);
